@@ src/memory_lcd_spi_receiver_assert.svh @@
// ----------------------------------------------------------------------------
// memory lcd receiver assertion macros
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MEMORY_LCD_SPI_RECEIVER_ASSERT_SVH
`define MEMORY_LCD_SPI_RECEIVER_ASSERT_SVH

// consequent checked in the same cycle
`define MLCD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("memory lcd receiver: same-cycle property failed");

// consequent checked in the next cycle
`define MLCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("memory lcd receiver: next-cycle property failed");

`endif

@@ src/mlcd_pkg.sv @@
// ----------------------------------------------------------------------------
// mlcd_pkg
// Panel geometry, derived widths and shared types of the memory lcd receiver.
// ----------------------------------------------------------------------------
package mlcd_pkg;

    localparam int PANEL_WIDTH  = 400;
    localparam int PANEL_HEIGHT = 240;

    localparam int LINE_BYTES  = (PANEL_WIDTH + 7) / 8;
    localparam int FRAME_DEPTH = PANEL_HEIGHT * LINE_BYTES;
    localparam int FRAME_AW    = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
    localparam int LINE_AW     = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
    localparam int POS_W       = $clog2(LINE_BYTES + 1);
    localparam int ROW_AW      = (PANEL_HEIGHT > 1) ? $clog2(PANEL_HEIGHT) : 1;

    localparam int MODE_W = 2;
    localparam int BYTE_W = 8;
    localparam int COL_W  = 9;
    localparam int ROW_W  = 8;
    localparam int CNT_W  = 32;

    typedef enum logic [MODE_W-1:0] {
        MODE_BYTE   = 2'd0,
        MODE_SELECT = 2'd1,
        MODE_ENABLE = 2'd2,
        MODE_READ   = 2'd3
    } mode_t;

    typedef struct packed {
        logic              clear_all;
        logic              set_en;
        logic [ROW_AW-1:0] set_row;
    } row_valid_ctl_t;

endpackage

@@ src/mlcd_ram.sv @@
// ----------------------------------------------------------------------------
// mlcd_ram
// Simple dual-port synchronous ram, one write and one registered read port.
// ----------------------------------------------------------------------------
module mlcd_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 2,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/mlcd_row_valid.sv @@
// ----------------------------------------------------------------------------
// mlcd_row_valid
// One flag per panel row; a row without its flag reads as all white.
// ----------------------------------------------------------------------------
module mlcd_row_valid (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mlcd_pkg::row_valid_ctl_t    ctl,
    input  logic [mlcd_pkg::ROW_AW-1:0] query_row,
    output logic                        query_valid
);

    import mlcd_pkg::*;

    logic [PANEL_HEIGHT-1:0] valid_reg;
    logic [PANEL_HEIGHT-1:0] valid_next;

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.clear_all)
        begin
            valid_next = '0;
        end
        if (ctl.set_en)
        begin
            valid_next[ctl.set_row] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign query_valid = valid_reg[query_row];

endmodule

@@ src/mlcd_ctrl.sv @@
// ----------------------------------------------------------------------------
// mlcd_ctrl
// Request sequencer: protocol parser, line commit copy, pixel read and the
// result register.
// ----------------------------------------------------------------------------
module mlcd_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [mlcd_pkg::MODE_W-1:0]   mode,
    input  logic [mlcd_pkg::BYTE_W-1:0]   wire_byte,
    input  logic                          pin_level,
    input  logic [mlcd_pkg::COL_W-1:0]    read_column,
    input  logic [mlcd_pkg::ROW_W-1:0]    read_row,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          pixel_white,
    output logic                          display_on,
    output logic                          vcom_now,
    output logic [mlcd_pkg::CNT_W-1:0]    vcom_change_count,
    output logic [mlcd_pkg::CNT_W-1:0]    protocol_error_count,
    output logic                          selected,
    output logic                          frame_rd_en,
    output logic [mlcd_pkg::FRAME_AW-1:0] frame_rd_addr,
    input  logic [mlcd_pkg::BYTE_W-1:0]   frame_rd_data,
    output logic                          frame_wr_en,
    output logic [mlcd_pkg::FRAME_AW-1:0] frame_wr_addr,
    output logic                          line_wr_en,
    output logic [mlcd_pkg::LINE_AW-1:0]  line_wr_addr,
    output logic                          line_rd_en,
    output logic [mlcd_pkg::LINE_AW-1:0]  line_rd_addr,
    output mlcd_pkg::row_valid_ctl_t      row_ctl,
    output logic [mlcd_pkg::ROW_AW-1:0]   row_query,
    input  logic                          row_valid
);

    import mlcd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RDWAIT,
        S_COPY,
        S_EMIT
    } state_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_COMMAND,
        PH_ADDR,
        PH_PIXELS,
        PH_TRAILER,
        PH_DRAIN
    } phase_t;

    localparam logic [3:0] CMD_VCOM  = 4'h0;
    localparam logic [3:0] CMD_WRITE = 4'h1;
    localparam logic [3:0] CMD_CLEAR = 4'h4;
    localparam int         VCOM_BIT  = 6;

    function automatic logic [BYTE_W-1:0] flip8(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] r;
        for (int i = 0; i < BYTE_W; i++)
        begin
            r[i] = v[BYTE_W-1-i];
        end
        return r;
    endfunction

    state_t            state_reg,   state_next;
    phase_t            phase_reg,   phase_next;
    logic [ROW_W-1:0]  target_reg,  target_next;
    logic [POS_W-1:0]  pos_reg,     pos_next;
    logic              sel_reg,     sel_next;
    logic              en_reg,      en_next;
    logic              vcom_reg,    vcom_next;
    logic [CNT_W-1:0]  vchg_reg,    vchg_next;
    logic [CNT_W-1:0]  err_reg,     err_next;
    logic [POS_W-1:0]  cnt_reg,     cnt_next;
    logic [FRAME_AW-1:0] base_reg,  base_next;
    logic              rd_ok_reg,   rd_ok_next;
    logic              row_ok_reg,  row_ok_next;
    logic [2:0]        bit_reg,     bit_next;
    logic              pix_reg,     pix_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_pix_reg,   out_pix_next;
    logic              out_en_reg,    out_en_next;
    logic              out_vcom_reg,  out_vcom_next;
    logic [CNT_W-1:0]  out_vchg_reg,  out_vchg_next;
    logic [CNT_W-1:0]  out_err_reg,   out_err_next;
    logic              out_sel_reg,   out_sel_next;

    logic [BYTE_W-1:0] flipped;
    logic              in_range;
    logic [POS_W-1:0]  pos_inc;
    logic              line_full;
    logic              line_on_panel;

    assign flipped       = flip8(wire_byte);
    assign in_range      = (32'(read_column) < PANEL_WIDTH) && (32'(read_row) < PANEL_HEIGHT);
    assign pos_inc       = pos_reg + 1'b1;
    assign line_full     = (32'(pos_inc) == LINE_BYTES);
    assign line_on_panel = (32'(target_reg) <= PANEL_HEIGHT);

    assign in_ready      = (state_reg == S_IDLE);
    assign frame_rd_addr = FRAME_AW'(32'(read_row) * LINE_BYTES + 32'(read_column[COL_W-1:3]));
    assign row_query     = read_row[ROW_AW-1:0];
    assign line_wr_addr  = pos_reg[LINE_AW-1:0];
    assign line_rd_addr  = cnt_reg[LINE_AW-1:0];
    // write trails the read of the line buffer: each byte is written in the cycle after its read
    assign frame_wr_addr = base_reg + FRAME_AW'(cnt_reg - 1'b1);

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        target_next    = target_reg;
        pos_next       = pos_reg;
        sel_next       = sel_reg;
        en_next        = en_reg;
        vcom_next      = vcom_reg;
        vchg_next      = vchg_reg;
        err_next       = err_reg;
        cnt_next       = cnt_reg;
        base_next      = base_reg;
        rd_ok_next     = rd_ok_reg;
        row_ok_next    = row_ok_reg;
        bit_next       = bit_reg;
        pix_next       = pix_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_pix_next   = out_pix_reg;
        out_en_next    = out_en_reg;
        out_vcom_next  = out_vcom_reg;
        out_vchg_next  = out_vchg_reg;
        out_err_next   = out_err_reg;
        out_sel_next   = out_sel_reg;
        frame_rd_en    = 1'b0;
        frame_wr_en    = 1'b0;
        line_wr_en     = 1'b0;
        line_rd_en     = 1'b0;
        row_ctl        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EMIT;
                    pix_next   = 1'b0;
                    unique case (mode_t'(mode))
                        MODE_BYTE:
                        begin
                            if (!sel_reg)
                            begin
                                err_next = err_reg + 1'b1;
                            end
                            else
                            begin
                                unique case (phase_reg)
                                    PH_COMMAND:
                                    begin
                                        if (flipped[VCOM_BIT] != vcom_reg)
                                        begin
                                            vchg_next = vchg_reg + 1'b1;
                                        end
                                        vcom_next = flipped[VCOM_BIT];
                                        unique case (flipped[3:0])
                                            CMD_WRITE:
                                            begin
                                                phase_next = PH_ADDR;
                                            end
                                            CMD_CLEAR:
                                            begin
                                                row_ctl.clear_all = 1'b1;
                                                phase_next        = PH_DRAIN;
                                            end
                                            CMD_VCOM:
                                            begin
                                                phase_next = PH_DRAIN;
                                            end
                                            default:
                                            begin
                                                err_next   = err_reg + 1'b1;
                                                phase_next = PH_DRAIN;
                                            end
                                        endcase
                                    end
                                    PH_ADDR:
                                    begin
                                        if (flipped == '0)
                                        begin
                                            phase_next = PH_DRAIN;
                                        end
                                        else
                                        begin
                                            target_next = flipped;
                                            pos_next    = '0;
                                            phase_next  = PH_PIXELS;
                                        end
                                    end
                                    PH_PIXELS:
                                    begin
                                        line_wr_en = 1'b1;
                                        pos_next   = pos_inc;
                                        if (line_full)
                                        begin
                                            phase_next = PH_TRAILER;
                                            if (line_on_panel)
                                            begin
                                                state_next = S_COPY;
                                                cnt_next   = '0;
                                                base_next  = FRAME_AW'(
                                                    (32'(target_reg) - 1) * LINE_BYTES);
                                            end
                                            else
                                            begin
                                                err_next = err_reg + 1'b1;
                                            end
                                        end
                                    end
                                    PH_TRAILER:
                                    begin
                                        phase_next = PH_ADDR;
                                    end
                                    default:
                                    begin
                                        // idle or draining: byte is ignored
                                    end
                                endcase
                            end
                        end
                        MODE_SELECT:
                        begin
                            if (pin_level && !sel_reg)
                            begin
                                phase_next = PH_COMMAND;
                            end
                            else if (!pin_level && sel_reg)
                            begin
                                if (phase_reg == PH_PIXELS)
                                begin
                                    err_next = err_reg + 1'b1;
                                end
                                phase_next = PH_IDLE;
                            end
                            sel_next = pin_level;
                        end
                        MODE_ENABLE:
                        begin
                            en_next = pin_level;
                        end
                        MODE_READ:
                        begin
                            frame_rd_en = in_range;
                            rd_ok_next  = in_range;
                            row_ok_next = in_range && row_valid;
                            bit_next    = read_column[2:0];
                            state_next  = S_RDWAIT;
                        end
                    endcase
                end
            end
            S_RDWAIT:
            begin
                if (!rd_ok_reg)
                begin
                    pix_next = 1'b0;
                end
                else if (!row_ok_reg)
                begin
                    pix_next = 1'b1;
                end
                else
                begin
                    pix_next = frame_rd_data[3'd7 - bit_reg];
                end
                state_next = S_EMIT;
            end
            S_COPY:
            begin
                line_rd_en  = (32'(cnt_reg) < LINE_BYTES);
                frame_wr_en = (cnt_reg != '0);
                cnt_next    = cnt_reg + 1'b1;
                if (32'(cnt_reg) == LINE_BYTES)
                begin
                    row_ctl.set_en  = 1'b1;
                    row_ctl.set_row = ROW_AW'(target_reg - 1'b1);
                    state_next      = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_pix_next   = pix_reg;
                    out_en_next    = en_reg;
                    out_vcom_next  = vcom_reg;
                    out_vchg_next  = vchg_reg;
                    out_err_next   = err_reg;
                    out_sel_next   = sel_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_IDLE;
            target_reg    <= '0;
            pos_reg       <= '0;
            sel_reg       <= 1'b0;
            en_reg        <= 1'b0;
            vcom_reg      <= 1'b0;
            vchg_reg      <= '0;
            err_reg       <= '0;
            cnt_reg       <= '0;
            base_reg      <= '0;
            rd_ok_reg     <= 1'b0;
            row_ok_reg    <= 1'b0;
            bit_reg       <= '0;
            pix_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_pix_reg   <= 1'b0;
            out_en_reg    <= 1'b0;
            out_vcom_reg  <= 1'b0;
            out_vchg_reg  <= '0;
            out_err_reg   <= '0;
            out_sel_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            target_reg    <= target_next;
            pos_reg       <= pos_next;
            sel_reg       <= sel_next;
            en_reg        <= en_next;
            vcom_reg      <= vcom_next;
            vchg_reg      <= vchg_next;
            err_reg       <= err_next;
            cnt_reg       <= cnt_next;
            base_reg      <= base_next;
            rd_ok_reg     <= rd_ok_next;
            row_ok_reg    <= row_ok_next;
            bit_reg       <= bit_next;
            pix_reg       <= pix_next;
            out_valid_reg <= out_valid_next;
            out_pix_reg   <= out_pix_next;
            out_en_reg    <= out_en_next;
            out_vcom_reg  <= out_vcom_next;
            out_vchg_reg  <= out_vchg_next;
            out_err_reg   <= out_err_next;
            out_sel_reg   <= out_sel_next;
        end
    end

    assign out_valid            = out_valid_reg;
    assign pixel_white          = out_pix_reg;
    assign display_on           = out_en_reg;
    assign vcom_now             = out_vcom_reg;
    assign vcom_change_count    = out_vchg_reg;
    assign protocol_error_count = out_err_reg;
    assign selected             = out_sel_reg;

endmodule

@@ src/memory_lcd_spi_receiver.sv @@
// ----------------------------------------------------------------------------
// memory_lcd_spi_receiver
// Panel-side receiver of the memory lcd serial protocol with frame store.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one event per request: a wire
// byte, a chip select level, a display enable level or a pixel read. The
// output channel (out_valid/out_ready) returns exactly one result per
// request, in order, through a result register.
// A byte, select or enable request passes through the emit state into the
// result register; a pixel read first waits in S_RDWAIT on the frame ram.
// The byte that completes a line on the panel starts a copy from the line
// buffer into the frame ram in S_COPY, one byte a cycle, before its result
// is emitted. Only one request is in work at a time.
// in_ready is high whenever no request is in work; the next request is
// taken while a result still waits in the result register, and a result
// that cannot be handed over holds the sequencer until out_ready.
// Reset clears all row flags at once, so the whole frame reads white with
// no clearing pass; the clear command does the same.
// ----------------------------------------------------------------------------
module memory_lcd_spi_receiver (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [mlcd_pkg::MODE_W-1:0] mode,
    input  logic [mlcd_pkg::BYTE_W-1:0] wire_byte,
    input  logic                        pin_level,
    input  logic [mlcd_pkg::COL_W-1:0]  read_column,
    input  logic [mlcd_pkg::ROW_W-1:0]  read_row,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        pixel_white,
    output logic                        display_on,
    output logic                        vcom_now,
    output logic [mlcd_pkg::CNT_W-1:0]  vcom_change_count,
    output logic [mlcd_pkg::CNT_W-1:0]  protocol_error_count,
    output logic                        selected
);

    import mlcd_pkg::*;

    logic                frame_rd_en;
    logic [FRAME_AW-1:0] frame_rd_addr;
    logic [BYTE_W-1:0]   frame_rd_data;
    logic                frame_wr_en;
    logic [FRAME_AW-1:0] frame_wr_addr;
    logic                line_wr_en;
    logic [LINE_AW-1:0]  line_wr_addr;
    logic                line_rd_en;
    logic [LINE_AW-1:0]  line_rd_addr;
    logic [BYTE_W-1:0]   line_rd_data;
    row_valid_ctl_t      row_ctl;
    logic [ROW_AW-1:0]   row_query;
    logic                row_valid;

    mlcd_ctrl u_ctrl (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (in_valid),
        .in_ready             (in_ready),
        .mode                 (mode),
        .wire_byte            (wire_byte),
        .pin_level            (pin_level),
        .read_column          (read_column),
        .read_row             (read_row),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .pixel_white          (pixel_white),
        .display_on           (display_on),
        .vcom_now             (vcom_now),
        .vcom_change_count    (vcom_change_count),
        .protocol_error_count (protocol_error_count),
        .selected             (selected),
        .frame_rd_en          (frame_rd_en),
        .frame_rd_addr        (frame_rd_addr),
        .frame_rd_data        (frame_rd_data),
        .frame_wr_en          (frame_wr_en),
        .frame_wr_addr        (frame_wr_addr),
        .line_wr_en           (line_wr_en),
        .line_wr_addr         (line_wr_addr),
        .line_rd_en           (line_rd_en),
        .line_rd_addr         (line_rd_addr),
        .row_ctl              (row_ctl),
        .row_query            (row_query),
        .row_valid            (row_valid)
    );

    // pixel bytes of the line in progress
    mlcd_ram #(
        .WIDTH  (BYTE_W),
        .DEPTH  (LINE_BYTES),
        .ADDR_W (LINE_AW)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (line_wr_en),
        .wr_addr (line_wr_addr),
        .wr_data (wire_byte),
        .rd_en   (line_rd_en),
        .rd_addr (line_rd_addr),
        .rd_data (line_rd_data)
    );

    mlcd_ram #(
        .WIDTH  (BYTE_W),
        .DEPTH  (FRAME_DEPTH),
        .ADDR_W (FRAME_AW)
    ) u_frame_ram (
        .clk     (clk),
        .wr_en   (frame_wr_en),
        .wr_addr (frame_wr_addr),
        .wr_data (line_rd_data),
        .rd_en   (frame_rd_en),
        .rd_addr (frame_rd_addr),
        .rd_data (frame_rd_data)
    );

    mlcd_row_valid u_row_valid (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (row_ctl),
        .query_row   (row_query),
        .query_valid (row_valid)
    );

endmodule

@@ src/mlcd_checker.sv @@
// ----------------------------------------------------------------------------
// mlcd_checker
// Port-level properties of the memory lcd receiver, bound to the top level.
// ----------------------------------------------------------------------------
`include "memory_lcd_spi_receiver_assert.svh"

module mlcd_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [mlcd_pkg::CNT_W-1:0]  protocol_error_count
);

    // a stalled result stays valid and keeps its protocol error count
    `MLCD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(protocol_error_count))

    // one request in work at a time
    `MLCD_ASSERT_NEXT(a_one_request, in_valid && in_ready, !in_ready)

    // loading a fresh result frees the input side in the same cycle
    `MLCD_ASSERT_NOW(a_load_frees_input, $rose(out_valid), in_ready)

    // an idle receiver stays ready
    `MLCD_ASSERT_NEXT(a_ready_waits, in_ready && !in_valid, in_ready)

endmodule

bind memory_lcd_spi_receiver mlcd_checker u_mlcd_checker (.*);
